### design/rgbspi_pkg.sv
// Shared constants, types and the line-code function of the RGB strip SPI encoder.
package rgbspi_pkg;

  localparam int unsigned PIXELS_DEF = 32;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COLOR_W    = 3 * BYTE_W;
  localparam int unsigned CODE_W     = 3 * BYTE_W;

  localparam logic [1:0] CMD_SET_ONE = 2'd0;
  localparam logic [1:0] CMD_SET_ALL = 2'd1;
  localparam logic [1:0] CMD_SHOW    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHOW,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic                we;
    logic [CNT_W-1:0]    waddr;
    logic [COLOR_W-1:0]  wdata;
    logic                re;
    logic [CNT_W-1:0]    raddr;
  } store_req_t;

  typedef struct packed {
    logic load_reset;
    logic reset_last;
    logic pix_valid;
    logic pix_last;
  } out_ctl_t;

  // Each data bit b, MSB first, becomes the three line bits 1,b,0.
  function automatic logic [CODE_W-1:0] encode_byte(input logic [BYTE_W-1:0] v);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      code[3*i+2] = 1'b1;
      code[3*i+1] = v[i];
      code[3*i]   = 1'b0;
    end
    return code;
  endfunction

endpackage

### design/rgbspi_store.sv
// Pixel frame store: one write port, one registered read port, per-entry valid bits.
module rgbspi_store #(
  parameter int unsigned PIXELS = rgbspi_pkg::PIXELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rgbspi_pkg::store_req_t      req_i,
  output logic [rgbspi_pkg::COLOR_W-1:0] rdata_o,
  output logic                        rvalid_o
);
  import rgbspi_pkg::*;

  localparam int unsigned AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  logic [COLOR_W-1:0] mem [PIXELS];
  logic [PIXELS-1:0]  valid_q;
  logic [COLOR_W-1:0] rdata_q;
  logic               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[AW-1:0]];
    end
  end

  // An entry that was never written since reset reads as black.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr[AW-1:0]] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr[AW-1:0]];
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.we |-> (req_i.waddr < CNT_W'(PIXELS)))
    else $error("store write beyond depth");

  a_raddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.re |-> (req_i.raddr < CNT_W'(PIXELS)))
    else $error("store read beyond depth");

  a_no_wr_rd_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.we && req_i.re))
    else $error("store written while a frame is read out");

endmodule

### design/rgbspi_out.sv
// Result stage: encodes a stored pixel or forms the reset-gap item into a registered result; it never stalls.
module rgbspi_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rgbspi_pkg::out_ctl_t          ctl_i,
  input  logic [rgbspi_pkg::COLOR_W-1:0] rdata_i,
  input  logic                          rvalid_i,
  output logic                          out_valid_o,
  output logic                          is_reset_o,
  output logic [rgbspi_pkg::CODE_W-1:0] red_code_o,
  output logic [rgbspi_pkg::CODE_W-1:0] green_code_o,
  output logic [rgbspi_pkg::CODE_W-1:0] blue_code_o,
  output logic                          last_o
);
  import rgbspi_pkg::*;

  logic                out_valid_q, out_valid_d;
  logic                is_reset_q, is_reset_d;
  logic                last_q, last_d;
  logic [CODE_W-1:0]   red_q, red_d;
  logic [CODE_W-1:0]   green_q, green_d;
  logic [CODE_W-1:0]   blue_q, blue_d;
  logic [COLOR_W-1:0]  pix;

  always_comb begin
    pix         = rvalid_i ? rdata_i : '0;
    out_valid_d = 1'b0;
    is_reset_d  = 1'b0;
    last_d      = 1'b0;
    red_d       = '0;
    green_d     = '0;
    blue_d      = '0;
    priority if (ctl_i.load_reset) begin
      out_valid_d = 1'b1;
      is_reset_d  = 1'b1;
      last_d      = ctl_i.reset_last;
    end else if (ctl_i.pix_valid) begin
      out_valid_d = 1'b1;
      last_d      = ctl_i.pix_last;
      red_d       = encode_byte(pix[COLOR_W-1 -: BYTE_W]);
      green_d     = encode_byte(pix[BYTE_W +: BYTE_W]);
      blue_d      = encode_byte(pix[BYTE_W-1:0]);
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_reset_q <= is_reset_d;
    last_q     <= last_d;
    red_q      <= red_d;
    green_q    <= green_d;
    blue_q     <= blue_d;
  end

  assign out_valid_o  = out_valid_q;
  assign is_reset_o   = is_reset_q;
  assign last_o       = last_q;
  assign red_code_o   = red_q;
  assign green_code_o = green_q;
  assign blue_code_o  = blue_q;

  a_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.load_reset && ctl_i.pix_valid))
    else $error("reset-gap item and pixel item in the same cycle");

  a_pixel_after_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.load_reset && !ctl_i.reset_last) |=> ##1 ctl_i.pix_valid)
    else $error("first pixel did not follow the reset-gap item");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.pix_valid && !ctl_i.pix_last) |=> ctl_i.pix_valid)
    else $error("pixel stream broke off before its last item");

endmodule

### design/rgbspi_ctrl.sv
// Command sequencer: pixel count register, set-one/set-all writes and show read-out.
module rgbspi_ctrl #(
  parameter int unsigned PIXELS = rgbspi_pkg::PIXELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    command_i,
  input  logic [rgbspi_pkg::IDX_W-1:0]  pixel_index_i,
  input  logic [rgbspi_pkg::COLOR_W-1:0] colour_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rgbspi_pkg::CNT_W-1:0]  cfg_data_i,
  output rgbspi_pkg::store_req_t        req_o,
  output rgbspi_pkg::out_ctl_t          out_ctl_o
);
  import rgbspi_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [COLOR_W-1:0]  colour_q, colour_d;
  logic                pend_q, pend_d;
  logic                pend_last_q, pend_last_d;
  logic [CNT_W-1:0]    n_eff;
  logic [CNT_W-1:0]    idx_ext;
  logic [CNT_W-1:0]    cnt_inc;
  logic                accept;

  assign n_eff   = (count_q > CNT_W'(PIXELS)) ? CNT_W'(PIXELS) : count_q;
  assign idx_ext = CNT_W'(pixel_index_i);
  assign cnt_inc = cnt_q + CNT_W'(1);
  // A pending read must land in the result stage before a new command starts.
  assign busy_o      = (state_q != ST_IDLE) || pend_q;
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    colour_d    = colour_q;
    pend_d      = 1'b0;
    pend_last_d = 1'b0;
    req_o       = '0;
    out_ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_SET_ONE: begin
              if (idx_ext < n_eff) begin
                req_o.we    = 1'b1;
                req_o.waddr = idx_ext;
                req_o.wdata = colour_i;
              end
            end
            CMD_SET_ALL: begin
              cnt_d    = '0;
              n_d      = n_eff;
              colour_d = colour_i;
              if (n_eff != '0) begin
                state_d = ST_FILL;
              end
            end
            CMD_SHOW: begin
              out_ctl_o.load_reset = 1'b1;
              out_ctl_o.reset_last = (n_eff == '0);
              cnt_d                = '0;
              n_d                  = n_eff;
              if (n_eff != '0) begin
                state_d = ST_SHOW;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SHOW: begin
        req_o.re    = 1'b1;
        req_o.raddr = cnt_q;
        pend_d      = 1'b1;
        pend_last_d = (cnt_inc == n_q);
        cnt_d       = cnt_inc;
        if (cnt_inc == n_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        req_o.we    = 1'b1;
        req_o.waddr = cnt_q;
        req_o.wdata = colour_q;
        cnt_d       = cnt_inc;
        if (cnt_inc == n_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_ctl_o.pix_valid = pend_q;
    out_ctl_o.pix_last  = pend_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CNT_W'(PIXELS);
      cnt_q       <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    colour_q <= colour_d;
  end

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cnt_q < n_q) && (n_q <= CNT_W'(PIXELS)))
    else $error("walk counter outside the active pixel range");

  a_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !pend_q)
    else $error("command accepted while a store read is in flight");

  a_show_last_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHOW && cnt_inc == n_q) |=> (state_q == ST_IDLE) && pend_q && pend_last_q)
    else $error("show run did not end on its final pixel");

endmodule

### design/rgb_strip_spi_bit_encoder_core.sv
// Top level of the RGB strip SPI bit encoder: frame store, sequencer and result stage.
// A command is taken when start_i is high and busy_o is low; there are n = min(pixel
// count, PIXELS) active pixels. Set-one writes one pixel in the cycle it is taken, if its
// index is below n. Set-all writes the n active pixels one per cycle through the single
// store write port, so busy_o stays high until the last is written. Show puts the
// reset-gap item on the outputs in the cycle after acceptance, then reads the store one
// pixel a cycle through its read register and the result register; busy_o holds until
// the last read reaches the result stage. Every result is valid for exactly one cycle
// while out_valid_o is high and cannot be held off; last_o marks the final result of a
// show. The store reads as black after reset without a clearing pass. The user must
// write the pixel count register through cfg_valid_i/cfg_ready_o only while the block is
// idle; the block does not enforce it. cfg_ready_o is always high.
module rgb_strip_spi_bit_encoder_core #(
  parameter int unsigned PIXELS = rgbspi_pkg::PIXELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    command_i,
  input  logic [rgbspi_pkg::IDX_W-1:0]  pixel_index_i,
  input  logic [rgbspi_pkg::BYTE_W-1:0] red_i,
  input  logic [rgbspi_pkg::BYTE_W-1:0] green_i,
  input  logic [rgbspi_pkg::BYTE_W-1:0] blue_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rgbspi_pkg::CNT_W-1:0]  cfg_data_i,
  output logic                          out_valid_o,
  output logic                          is_reset_o,
  output logic [rgbspi_pkg::CODE_W-1:0] red_code_o,
  output logic [rgbspi_pkg::CODE_W-1:0] green_code_o,
  output logic [rgbspi_pkg::CODE_W-1:0] blue_code_o,
  output logic                          last_o
);
  import rgbspi_pkg::*;

  store_req_t          req;
  out_ctl_t            out_ctl;
  logic [COLOR_W-1:0]  rdata;
  logic                rvalid;

  rgbspi_ctrl #(
    .PIXELS(PIXELS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .pixel_index_i (pixel_index_i),
    .colour_i      ({red_i, green_i, blue_i}),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .req_o         (req),
    .out_ctl_o     (out_ctl)
  );

  rgbspi_store #(
    .PIXELS(PIXELS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rdata_o  (rdata),
    .rvalid_o (rvalid)
  );

  rgbspi_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (out_ctl),
    .rdata_i      (rdata),
    .rvalid_i     (rvalid),
    .out_valid_o  (out_valid_o),
    .is_reset_o   (is_reset_o),
    .red_code_o   (red_code_o),
    .green_code_o (green_code_o),
    .blue_code_o  (blue_code_o),
    .last_o       (last_o)
  );

endmodule

### tb/rgb_strip_spi_bit_encoder_core_tb.sv
// Self-checking testbench for the RGB strip SPI bit encoder: frame store commands and show output.
`timescale 1ns / 100ps

module rgb_strip_spi_bit_encoder_core_tb;
  import rgbspi_pkg::*;

  localparam int unsigned STORE_DEPTH    = PIXELS_DEF;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam logic [23:0] BLACK_PATTERN  = 24'h924924;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic                is_reset;
    logic [CODE_W-1:0]   red;
    logic [CODE_W-1:0]   green;
    logic [CODE_W-1:0]   blue;
    logic                last;
  } led_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          command_i;
  logic [IDX_W-1:0]    pixel_index_i;
  logic [BYTE_W-1:0]   red_i;
  logic [BYTE_W-1:0]   green_i;
  logic [BYTE_W-1:0]   blue_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_data_i;
  logic                out_valid_o;
  logic                is_reset_o;
  logic [CODE_W-1:0]   red_code_o;
  logic [CODE_W-1:0]   green_code_o;
  logic [CODE_W-1:0]   blue_code_o;
  logic                last_o;

  // Predictor state: shadow frame store and the pixel count register.
  logic [COLOR_W-1:0]  frame_mem [STORE_DEPTH];
  logic [CNT_W-1:0]    strip_len;
  led_item_t           led_items_q[$];
  int                  error_count;
  int                  quiet_cycles;

  rgb_strip_spi_bit_encoder_core #(
    .PIXELS(STORE_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .pixel_index_i(pixel_index_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .is_reset_o   (is_reset_o),
    .red_code_o   (red_code_o),
    .green_code_o (green_code_o),
    .blue_code_o  (blue_code_o),
    .last_o       (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Every data bit lands in the middle slot of its three-bit line symbol.
  function automatic logic [CODE_W-1:0] line_pattern(input logic [BYTE_W-1:0] value);
    logic [CODE_W-1:0] pattern;
    pattern = BLACK_PATTERN;
    for (int i = 0; i < BYTE_W; i++) begin
      pattern[3*i+1] = value[i];
    end
    return pattern;
  endfunction

  function automatic int active_pixels();
    return (strip_len > STORE_DEPTH) ? STORE_DEPTH : int'(strip_len);
  endfunction

  function automatic void predict_frame(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                                        input logic [BYTE_W-1:0] r,
                                        input logic [BYTE_W-1:0] g,
                                        input logic [BYTE_W-1:0] b);
    int        n;
    led_item_t item;
    n = active_pixels();
    case (cmd)
      CMD_SET_ONE: begin
        if (int'(idx) < n) frame_mem[idx] = {r, g, b};
      end
      CMD_SET_ALL: begin
        for (int i = 0; i < n; i++) frame_mem[i] = {r, g, b};
      end
      CMD_SHOW: begin
        item = '0;
        item.is_reset = 1'b1;
        item.last     = (n == 0);
        led_items_q.push_back(item);
        for (int i = 0; i < n; i++) begin
          item.is_reset = 1'b0;
          item.red      = line_pattern(frame_mem[i][23:16]);
          item.green    = line_pattern(frame_mem[i][15:8]);
          item.blue     = line_pattern(frame_mem[i][7:0]);
          item.last     = (i + 1 == n);
          led_items_q.push_back(item);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [CODE_W-1:0] exp_val,
                                        input logic [CODE_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // Result checker: every strobe must match the oldest predicted item.
  always @(posedge clk_i) begin
    led_item_t exp_item;
    if (rst_ni && out_valid_o) begin
      if (led_items_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual reset=%b r=%h g=%h b=%h last=%b",
                 $time, is_reset_o, red_code_o, green_code_o, blue_code_o, last_o);
        error_count++;
      end else begin
        exp_item = led_items_q.pop_front();
        compare_field("is_reset", CODE_W'(exp_item.is_reset), CODE_W'(is_reset_o));
        compare_field("red_code", exp_item.red, red_code_o);
        compare_field("green_code", exp_item.green, green_code_o);
        compare_field("blue_code", exp_item.blue, blue_code_o);
        compare_field("last", CODE_W'(exp_item.last), CODE_W'(last_o));
      end
    end
  end

  // Counts cycles without any transaction on the command, result or config side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || out_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                          input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
                          input logic [BYTE_W-1:0] b, input int gap);
    @(negedge clk_i);
    start_i       <= 1'b1;
    command_i     <= cmd;
    pixel_index_i <= idx;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_frame(cmd, idx, r, g, b);
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drops start first so that the last command is not taken a second time.
  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (led_items_q.size() != 0) @(posedge clk_i);
  endtask

  // Idle the command side, collect every pending result and let a set-all finish.
  task automatic settle_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pixel_count(input logic [CNT_W-1:0] count);
    settle_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    strip_len = count;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_frame();
    send_cmd(CMD_SHOW, '0, '0, '0, '0, 0);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    send_cmd(CMD_SET_ONE, 5'd0, 8'hFF, 8'h00, 8'hFF, 0);
    send_cmd(CMD_SET_ONE, 5'd31, 8'h00, 8'hFF, 8'h00, 1);
    send_cmd(CMD_SET_ONE, 5'd21, 8'hAA, 8'h55, 8'h81, 0);
    send_cmd(CMD_SHOW, 5'd31, 8'hFF, 8'hFF, 8'hFF, 2);
  endtask

  task automatic test_unused_command();
    send_cmd(CMD_UNUSED, 5'd0, 8'hFF, 8'hFF, 8'hFF, 0);
    send_cmd(CMD_SHOW, '0, '0, '0, '0, 0);
  endtask

  task automatic test_zero_count();
    write_pixel_count(6'd0);
    send_cmd(CMD_SET_ONE, 5'd0, 8'h12, 8'h34, 8'h56, 0);
    send_cmd(CMD_SET_ALL, 5'd0, 8'h77, 8'h77, 8'h77, 0);
    send_cmd(CMD_SHOW, '0, '0, '0, '0, 0);
    write_pixel_count(6'd32);
    send_cmd(CMD_SHOW, '0, '0, '0, '0, 0);
  endtask

  task automatic test_single_pixel();
    write_pixel_count(6'd1);
    send_cmd(CMD_SET_ONE, 5'd1, 8'hDE, 8'hAD, 8'hBE, 0);
    send_cmd(CMD_SET_ONE, 5'd0, 8'h01, 8'h80, 8'h7F, 0);
    send_cmd(CMD_SHOW, '0, '0, '0, '0, 0);
  endtask

  task automatic test_set_all_reach();
    write_pixel_count(6'd5);
    send_cmd(CMD_SET_ALL, 5'd0, 8'h12, 8'h34, 8'h56, 0);
    write_pixel_count(6'd32);
    send_cmd(CMD_SHOW, '0, '0, '0, '0, 0);
  endtask

  task automatic test_count_above_store();
    write_pixel_count(6'd63);
    send_cmd(CMD_SET_ONE, 5'd31, 8'hC3, 8'h3C, 8'h5A, 0);
    send_cmd(CMD_SHOW, '0, '0, '0, '0, 0);
  endtask

  task automatic run_random_phase(input logic [CNT_W-1:0] count, input int n_items,
                                  input bit with_gaps);
    int               roll;
    int               n;
    logic [1:0]       cmd;
    logic [IDX_W-1:0] idx;
    write_pixel_count(count);
    n = active_pixels();
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      if (roll < 45) cmd = CMD_SET_ONE;
      else if (roll < 62) cmd = CMD_SET_ALL;
      else if (roll < 90) cmd = CMD_SHOW;
      else cmd = CMD_UNUSED;
      if (n > 0 && $urandom_range(99) < 80) idx = IDX_W'($urandom_range(n - 1));
      else idx = IDX_W'($urandom);
      send_cmd(cmd, idx, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
               with_gaps ? pick_gap() : 0);
      // Now and then the sender holds off until the whole frame has been seen.
      if ($urandom_range(99) < 5) wait_drained();
    end
  endtask

  task automatic test_random();
    run_random_phase(CNT_W'($urandom_range(31, 2)), 40, 1'b1);
    run_random_phase(6'd1, 35, 1'b1);
    run_random_phase(6'd32, 45, 1'b0);
    run_random_phase(6'd63, 35, 1'b1);
    run_random_phase(6'd0, 25, 1'b1);
    run_random_phase(CNT_W'($urandom_range(62, 33)), 35, 1'b1);
    run_random_phase(CNT_W'($urandom_range(32, 1)), 40, 1'b1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    command_i     = CMD_SET_ONE;
    pixel_index_i = '0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    error_count   = 0;
    strip_len     = CNT_W'(STORE_DEPTH);
    for (int i = 0; i < STORE_DEPTH; i++) frame_mem[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_frame();
    test_field_extremes();
    test_unused_command();
    test_zero_count();
    test_single_pixel();
    test_set_all_reach();
    test_count_above_store();
    test_random();

    settle_idle();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
